// ===== rtl/core/rspa_pkg.sv =====
// Shared constants and types for the reference-counted slot pool allocator.
`timescale 1ns / 1ps
package rspa_pkg;

  localparam int SLOTS        = 256;
  localparam int SLOT_W       = 8;
  localparam int HEADER_BYTES = 16;
  localparam int ADDR_W       = 21;
  localparam int CNT_W        = 9;
  localparam int PAY_W        = 13;
  localparam int RC_W         = 16;
  localparam int DIV_STEP_W   = 3;
  localparam logic [RC_W-1:0]  COUNT_MAX     = 16'hFFFF;
  localparam logic [PAY_W-1:0] PAYLOAD_RESET = 13'd64;
  localparam logic [PAY_W-1:0] PAYLOAD_MAX   = 13'd4096;

  typedef enum logic [1:0] {
    CMD_NEW     = 2'd0,
    CMD_SHARE   = 2'd1,
    CMD_RELEASE = 2'd2,
    CMD_CLEAR   = 2'd3
  } command_t;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_INVALID = 2'd1,
    ST_EMPTY   = 2'd2,
    ST_REFUSED = 2'd3
  } status_t;

  // controller to datapath
  typedef struct packed {
    logic ld_in;
    logic div_start;
    logic div_src;
    logic rd_q;
    logic save_src;
    logic rd_src;
    logic drop;
    logic rel_bad;
    logic share_op;
    logic pop_rd;
    logic pop_empty;
    logic new_op;
    logic addr_calc;
    logic clear;
    logic finish;
  } dp_cmd_t;

  // datapath to controller
  typedef struct packed {
    command_t cmd;
    logic     held_valid;
    logic     div_busy;
    logic     hnd_ok;
    logic     stack_empty;
    logic     out_free;
  } dp_stat_t;

endpackage

// ===== rtl/core/rspa_dp.sv =====
// Datapath: slot divider, count and free-stack memories, result registers.
`timescale 1ns / 1ps
module rspa_dp (
  input  logic                       clk,
  input  logic                       rst,
  input  rspa_pkg::dp_cmd_t          dcmd,
  output rspa_pkg::dp_stat_t         dstat,
  input  logic                       cfg_we,
  input  logic [rspa_pkg::PAY_W-1:0] cfg_wdata,
  input  logic [1:0]                 command,
  input  logic                       held_valid,
  input  logic [rspa_pkg::ADDR_W-1:0] held_address,
  input  logic [rspa_pkg::ADDR_W-1:0] source_address,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic [1:0]                 status,
  output logic [rspa_pkg::ADDR_W-1:0] address,
  output logic                       slot_freed,
  output logic [rspa_pkg::CNT_W-1:0] slots_in_use
);
  import rspa_pkg::*;

  logic [PAY_W-1:0]      payload_bytes;
  logic [PAY_W-1:0]      pay_clamped;
  logic [PAY_W-1:0]      gross;
  command_t              cmd_q;
  logic                  hv_q;
  logic [ADDR_W-1:0]     ha_q;
  logic [ADDR_W-1:0]     sa_q;
  logic [ADDR_W-1:0]     rem;
  logic [ADDR_W-1:0]     trial;
  logic [SLOT_W-1:0]     quot;
  logic [DIV_STEP_W-1:0] step;
  logic                  div_busy;
  logic                  range_ok;
  logic [ADDR_W-1:0]     div_a;
  logic [SLOT_W-1:0]     src_slot;
  logic [RC_W-1:0]       rc_mem [SLOTS];
  logic [SLOTS-1:0]      rc_vld;
  logic [RC_W-1:0]       rc_rdata;
  logic                  rc_rvld;
  logic [RC_W-1:0]       rc_val;
  logic                  rc_we;
  logic [SLOT_W-1:0]     rc_waddr;
  logic [RC_W-1:0]       rc_wdata;
  logic [SLOT_W-1:0]     rc_raddr;
  logic [SLOT_W-1:0]     stk_mem [SLOTS];
  logic [SLOTS-1:0]      stk_vld;
  logic [SLOT_W-1:0]     stk_rdata;
  logic                  stk_rvld;
  logic [SLOT_W-1:0]     pop_idx;
  logic [SLOT_W-1:0]     pop_slot;
  logic [CNT_W-1:0]      depth;
  logic [CNT_W-1:0]      acq;
  logic                  push;
  logic                  share_ok;
  logic [SLOT_W-1:0]     new_slot;
  logic [1:0]            res_status;
  logic [ADDR_W-1:0]     res_addr;
  logic                  res_freed;

  // configuration register and slot geometry
  always_ff @(posedge clk) begin
    if (rst) begin
      payload_bytes <= PAYLOAD_RESET;
    end else if (cfg_we) begin
      payload_bytes <= cfg_wdata;
    end
  end

  always_comb begin
    pay_clamped = payload_bytes;
    if (payload_bytes == '0) pay_clamped = PAY_W'(1);
    if (payload_bytes > PAYLOAD_MAX) pay_clamped = PAYLOAD_MAX;
  end
  assign gross = pay_clamped + PAY_W'(HEADER_BYTES);

  // latched input item
  always_ff @(posedge clk) begin
    if (dcmd.ld_in) begin
      cmd_q <= command_t'(command);
      hv_q  <= held_valid;
      ha_q  <= held_address;
      sa_q  <= source_address;
    end
  end

  // restoring divider, one quotient bit per cycle
  assign div_a = dcmd.div_src ? sa_q : ha_q;
  assign trial = {{(ADDR_W-PAY_W){1'b0}}, gross} << step;

  always_ff @(posedge clk) begin
    if (rst) begin
      div_busy <= 1'b0;
    end else if (dcmd.div_start) begin
      div_busy <= 1'b1;
    end else if (div_busy && step == '0) begin
      div_busy <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (dcmd.div_start) begin
      rem      <= div_a;
      quot     <= '0;
      step     <= DIV_STEP_W'(SLOT_W - 1);
      range_ok <= div_a < {gross, {SLOT_W{1'b0}}};
    end else if (div_busy) begin
      if (rem >= trial) begin
        rem        <= rem - trial;
        quot[step] <= 1'b1;
      end
      step <= step - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (dcmd.save_src) src_slot <= quot;
  end

  // reference count memory; an entry with no valid bit reads as zero
  assign rc_raddr = dcmd.rd_src ? src_slot : quot;
  assign rc_val   = rc_rvld ? rc_rdata : '0;
  assign share_ok = rc_val != '0 && rc_val != COUNT_MAX;
  assign pop_slot = stk_rvld ? stk_rdata : SLOT_W'(SLOTS - 1) - pop_idx;

  always_comb begin
    rc_we    = 1'b0;
    rc_waddr = quot;
    rc_wdata = rc_val - 1'b1;
    if (dcmd.drop) begin
      rc_we = 1'b1;
    end else if (dcmd.share_op && share_ok) begin
      rc_we    = 1'b1;
      rc_waddr = src_slot;
      rc_wdata = rc_val + 1'b1;
    end else if (dcmd.new_op) begin
      rc_we    = 1'b1;
      rc_waddr = pop_slot;
      rc_wdata = RC_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rc_we) rc_mem[rc_waddr] <= rc_wdata;
    if (dcmd.rd_q || dcmd.rd_src) rc_rdata <= rc_mem[rc_raddr];
  end

  always_ff @(posedge clk) begin
    if (rst || dcmd.clear) begin
      rc_vld  <= '0;
      rc_rvld <= 1'b0;
    end else begin
      if (rc_we) rc_vld[rc_waddr] <= 1'b1;
      if (dcmd.rd_q || dcmd.rd_src) rc_rvld <= rc_vld[rc_raddr];
    end
  end

  // free stack memory; an entry with no valid bit reads as its reset slot
  assign push = dcmd.drop && rc_val == RC_W'(1) && depth < CNT_W'(SLOTS);

  always_ff @(posedge clk) begin
    if (push) stk_mem[depth[SLOT_W-1:0]] <= quot;
    if (dcmd.pop_rd) begin
      stk_rdata <= stk_mem[SLOT_W'(depth - 1'b1)];
      pop_idx   <= SLOT_W'(depth - 1'b1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst || dcmd.clear) begin
      stk_vld  <= '0;
      stk_rvld <= 1'b0;
    end else begin
      if (push) stk_vld[depth[SLOT_W-1:0]] <= 1'b1;
      if (dcmd.pop_rd) stk_rvld <= stk_vld[SLOT_W'(depth - 1'b1)];
    end
  end

  // stack depth and acquired count
  always_ff @(posedge clk) begin
    if (rst || dcmd.clear) begin
      depth <= CNT_W'(SLOTS);
      acq   <= '0;
    end else if (dcmd.new_op) begin
      depth <= depth - 1'b1;
      acq   <= acq + 1'b1;
    end else if (dcmd.drop && rc_val == RC_W'(1)) begin
      if (push) depth <= depth + 1'b1;
      if (acq != '0) acq <= acq - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (dcmd.new_op) new_slot <= pop_slot;
  end

  // result of the item in progress
  always_ff @(posedge clk) begin
    if (dcmd.ld_in) begin
      res_status <= ST_OK;
      res_addr   <= '0;
      res_freed  <= 1'b0;
    end else begin
      if (dcmd.drop && rc_val == RC_W'(1)) res_freed <= 1'b1;
      if (dcmd.rel_bad) res_status <= ST_INVALID;
      if (dcmd.pop_empty) res_status <= ST_EMPTY;
      if (dcmd.share_op) begin
        if (share_ok) res_addr <= sa_q;
        else res_status <= ST_REFUSED;
      end
      if (dcmd.addr_calc) begin
        res_addr <= ADDR_W'({{PAY_W{1'b0}}, new_slot} * {{SLOT_W{1'b0}}, gross})
                    + ADDR_W'(HEADER_BYTES);
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (dcmd.finish) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (dcmd.finish) begin
      status       <= res_status;
      address      <= res_addr;
      slot_freed   <= res_freed;
      slots_in_use <= acq;
    end
  end

  // status back to the controller
  assign dstat.cmd         = cmd_q;
  assign dstat.held_valid  = hv_q;
  assign dstat.div_busy    = div_busy;
  assign dstat.hnd_ok      = range_ok && rem >= ADDR_W'(HEADER_BYTES) && rc_val != '0;
  assign dstat.stack_empty = depth == '0;
  assign dstat.out_free    = !out_valid || !out_stall;

`ifndef SYNTHESIS
  a_pool_balance: assert property (@(posedge clk) disable iff (rst)
    (depth + acq) == CNT_W'(SLOTS))
    else $error("free depth plus acquired count differs from pool size");
  a_depth_bound: assert property (@(posedge clk) disable iff (rst)
    depth <= CNT_W'(SLOTS))
    else $error("free stack depth above pool size");
  a_div_idle_start: assert property (@(posedge clk) disable iff (rst)
    dcmd.div_start |-> !div_busy)
    else $error("divider started while busy");
  a_pop_nonempty: assert property (@(posedge clk) disable iff (rst)
    dcmd.new_op |-> depth != '0)
    else $error("pop from an empty free stack");
`endif

endmodule

// ===== rtl/core/rspa_ctrl.sv =====
// Controller state machine sequencing each command over the datapath.
`timescale 1ns / 1ps
module rspa_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  rspa_pkg::dp_stat_t dstat,
  output rspa_pkg::dp_cmd_t  dcmd
);
  import rspa_pkg::*;

  typedef enum logic [13:0] {
    S_IDLE     = 14'b00000000000001,
    S_START    = 14'b00000000000010,
    S_DIV_SRC  = 14'b00000000000100,
    S_CHK_SRC  = 14'b00000000001000,
    S_DIV_HELD = 14'b00000000010000,
    S_DROP     = 14'b00000000100000,
    S_SHARE_RD = 14'b00000001000000,
    S_SHARE    = 14'b00000010000000,
    S_POP_RD   = 14'b00000100000000,
    S_NEW      = 14'b00001000000000,
    S_ADDR     = 14'b00010000000000,
    S_CLEAR    = 14'b00100000000000,
    S_DONE     = 14'b01000000000000,
    S_SPARE    = 14'b10000000000000
  } state_t;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else state <= state_next;
  end

  assign in_stall = state != S_IDLE;

  // next state and commands
  always_comb begin
    state_next = state;
    dcmd       = '0;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          dcmd.ld_in = 1'b1;
          state_next = S_START;
        end
      end
      S_START: begin
        if (dstat.cmd == CMD_CLEAR) begin
          state_next = S_CLEAR;
        end else if (dstat.cmd == CMD_SHARE) begin
          dcmd.div_start = 1'b1;
          dcmd.div_src   = 1'b1;
          state_next     = S_DIV_SRC;
        end else if (dstat.held_valid) begin
          dcmd.div_start = 1'b1;
          state_next     = S_DIV_HELD;
        end else if (dstat.cmd == CMD_NEW) begin
          state_next = S_POP_RD;
        end else begin
          state_next = S_DONE;
        end
      end
      S_DIV_SRC: begin
        if (!dstat.div_busy) begin
          dcmd.rd_q     = 1'b1;
          dcmd.save_src = 1'b1;
          state_next    = S_CHK_SRC;
        end
      end
      S_CHK_SRC: begin
        if (!dstat.hnd_ok) begin
          dcmd.rel_bad = 1'b1;
          state_next   = S_DONE;
        end else if (dstat.held_valid) begin
          dcmd.div_start = 1'b1;
          state_next     = S_DIV_HELD;
        end else begin
          state_next = S_SHARE_RD;
        end
      end
      S_DIV_HELD: begin
        if (!dstat.div_busy) begin
          dcmd.rd_q  = 1'b1;
          state_next = S_DROP;
        end
      end
      S_DROP: begin
        if (dstat.hnd_ok) dcmd.drop = 1'b1;
        else if (dstat.cmd == CMD_RELEASE) dcmd.rel_bad = 1'b1;
        if (dstat.cmd == CMD_NEW) state_next = S_POP_RD;
        else if (dstat.cmd == CMD_SHARE) state_next = S_SHARE_RD;
        else state_next = S_DONE;
      end
      S_SHARE_RD: begin
        dcmd.rd_src = 1'b1;
        state_next  = S_SHARE;
      end
      S_SHARE: begin
        dcmd.share_op = 1'b1;
        state_next    = S_DONE;
      end
      S_POP_RD: begin
        if (dstat.stack_empty) begin
          dcmd.pop_empty = 1'b1;
          state_next     = S_DONE;
        end else begin
          dcmd.pop_rd = 1'b1;
          state_next  = S_NEW;
        end
      end
      S_NEW: begin
        dcmd.new_op = 1'b1;
        state_next  = S_ADDR;
      end
      S_ADDR: begin
        dcmd.addr_calc = 1'b1;
        state_next     = S_DONE;
      end
      S_CLEAR: begin
        dcmd.clear = 1'b1;
        state_next = S_DONE;
      end
      S_DONE: begin
        if (dstat.out_free) begin
          dcmd.finish = 1'b1;
          state_next  = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

`ifndef SYNTHESIS
  a_accept_idle: assert property (@(posedge clk) disable iff (rst)
    dcmd.ld_in |=> state == S_START)
    else $error("transfer accepted outside idle");
  a_finish_free: assert property (@(posedge clk) disable iff (rst)
    dcmd.finish |-> dstat.out_free)
    else $error("result written over an untaken result");
  a_div_waits: assert property (@(posedge clk) disable iff (rst)
    (state == S_DIV_HELD && dstat.div_busy) |=> (state == S_DIV_HELD))
    else $error("held handle checked before divide finished");
`endif

endmodule

// ===== rtl/core/refcounted_slot_pool_allocator_core.sv =====
// Top level of the reference-counted slot pool allocator.
//
//   channel | direction | handshake             | payload
//   in      | input     | in_valid / in_stall   | command, held_valid, held_address,
//           |           |                       | source_address
//   out     | output    | out_valid / out_stall | status, address, slot_freed, slots_in_use
//   cfg     | input     | cfg_we                | cfg_wdata (payload_bytes)
//
// One item at a time; the input stalls from the accepting edge until the result is loaded.
// An address-to-slot split is a divider run followed by a count read. A share splits its source
// and, with a handle held, the held address too; a release or new splits only a held handle;
// a clear splits nothing. The core returns to idle before it takes the next transfer.
// Reset is synchronous; clear resets counts and stack by clearing their valid bits.
// A new item is accepted while a result waits under out_stall; its own result then waits.
`timescale 1ns / 1ps
module refcounted_slot_pool_allocator_core (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_we,
  input  logic [rspa_pkg::PAY_W-1:0]  cfg_wdata,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [1:0]                  command,
  input  logic                        held_valid,
  input  logic [rspa_pkg::ADDR_W-1:0] held_address,
  input  logic [rspa_pkg::ADDR_W-1:0] source_address,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [1:0]                  status,
  output logic [rspa_pkg::ADDR_W-1:0] address,
  output logic                        slot_freed,
  output logic [rspa_pkg::CNT_W-1:0]  slots_in_use
);
  import rspa_pkg::*;

  dp_cmd_t  dcmd;
  dp_stat_t dstat;

  rspa_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .dstat    (dstat),
    .dcmd     (dcmd)
  );

  rspa_dp u_dp (
    .clk            (clk),
    .rst            (rst),
    .dcmd           (dcmd),
    .dstat          (dstat),
    .cfg_we         (cfg_we),
    .cfg_wdata      (cfg_wdata),
    .command        (command),
    .held_valid     (held_valid),
    .held_address   (held_address),
    .source_address (source_address),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .status         (status),
    .address        (address),
    .slot_freed     (slot_freed),
    .slots_in_use   (slots_in_use)
  );

endmodule
